// File: hdl/mwm_pkg.sv
package mwm_pkg;

   // fixed field widths of the item ports
   localparam int ADDR_FIELD_W = 6;
   localparam int DATA_FIELD_W = 16;
   localparam int TPP_W        = 8;
   localparam int PHASE_W      = 4;

   // request opcodes
   localparam logic OP_READ  = 1'b0;
   localparam logic OP_WRITE = 1'b1;

   // start bit plus two opcode bits as sent on the wire
   localparam logic [2:0] CMD_EXT   = 3'b100;   // ewen / ewds family
   localparam logic [2:0] CMD_WRITE = 3'b101;
   localparam logic [2:0] CMD_READ  = 3'b110;

   // top two address bits that select ewen or ewds
   localparam logic [1:0] EXT_EWEN = 2'b11;
   localparam logic [1:0] EXT_EWDS = 2'b00;

   // sequencer phases
   localparam logic [PHASE_W-1:0] PH_IDLE      = 4'd0;
   localparam logic [PHASE_W-1:0] PH_EWEN      = 4'd1;
   localparam logic [PHASE_W-1:0] PH_EWEN_GAP  = 4'd2;
   localparam logic [PHASE_W-1:0] PH_WRITE     = 4'd3;
   localparam logic [PHASE_W-1:0] PH_WRITE_GAP = 4'd4;
   localparam logic [PHASE_W-1:0] PH_BUSY      = 4'd5;
   localparam logic [PHASE_W-1:0] PH_BUSY_GAP  = 4'd6;
   localparam logic [PHASE_W-1:0] PH_EWDS      = 4'd7;
   localparam logic [PHASE_W-1:0] PH_EWDS_GAP  = 4'd8;
   localparam logic [PHASE_W-1:0] PH_READ      = 4'd9;
   localparam logic [PHASE_W-1:0] PH_CAPTURE   = 4'd10;
   localparam logic [PHASE_W-1:0] PH_READ_GAP  = 4'd11;

   typedef struct packed {
      logic                    start_req;
      logic                    opcode;
      logic [ADDR_FIELD_W-1:0] word_address;
      logic [DATA_FIELD_W-1:0] write_word;
      logic                    serial_data_out;
   } req_item_type;

   typedef struct packed {
      logic                    chip_select;
      logic                    serial_clock;
      logic                    serial_data_in;
      logic                    busy_res;
      logic                    read_valid;
      logic [DATA_FIELD_W-1:0] read_word;
      logic                    write_done;
   } rsp_item_type;

endpackage

// File: hdl/mwm_seq.sv
module mwm_seq #(
   parameter int ADDR_BITS = 6,
   parameter int WORD_BITS = 16
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       step_en,
   input  mwm_pkg::req_item_type      item,
   input  logic [mwm_pkg::TPP_W-1:0]  ticks_per_phase,
   output mwm_pkg::rsp_item_type      result
);

   localparam int SHIFT_W = 3 + ADDR_BITS + WORD_BITS;
   localparam int CNT_W   = $clog2(SHIFT_W + 1);
   localparam int IDX_W   = $clog2(SHIFT_W);
   localparam int CMD_LEN = 3 + ADDR_BITS;
   localparam int CAP_LEN = WORD_BITS + 1;

   logic [mwm_pkg::PHASE_W-1:0] ph_ff, ph_in;
   logic [CNT_W-1:0]            cnt_ff, cnt_in;
   logic [SHIFT_W-1:0]          sh_ff, sh_in;
   logic [WORD_BITS-1:0]        rx_ff, rx_in;
   logic [mwm_pkg::TPP_W-1:0]   tmr_ff, tmr_in;
   logic [ADDR_BITS-1:0]        addr_ff, addr_in;
   logic [WORD_BITS-1:0]        data_ff, data_in;
   logic                        cs_ff, cs_in;
   logic                        sk_ff, sk_in;
   logic                        di_ff, di_in;

   logic [mwm_pkg::TPP_W-1:0]   restart;
   logic [CNT_W-1:0]            cnt_dec;
   logic [CNT_W-1:0]            cnt_m1;
   logic                        load;
   logic [mwm_pkg::PHASE_W-1:0] load_ph;
   logic [SHIFT_W-1:0]          load_bits;
   logic [CNT_W-1:0]            load_m1;
   logic                        rv;
   logic                        wd;

   // a zero setting counts as one tick per phase
   assign restart = (ticks_per_phase == '0) ? '0 : ticks_per_phase - 1'b1;
   assign cnt_dec = cnt_ff - 1'b1;
   assign cnt_m1  = cnt_dec - 1'b1;

   always_comb begin
      ph_in     = ph_ff;
      cnt_in    = cnt_ff;
      sh_in     = sh_ff;
      rx_in     = rx_ff;
      tmr_in    = tmr_ff;
      addr_in   = addr_ff;
      data_in   = data_ff;
      cs_in     = cs_ff;
      sk_in     = sk_ff;
      di_in     = di_ff;
      load      = 1'b0;
      load_ph   = mwm_pkg::PH_IDLE;
      load_bits = '0;
      load_m1   = '0;
      rv        = 1'b0;
      wd        = 1'b0;

      if (ph_ff == mwm_pkg::PH_IDLE) begin
         if (item.start_req) begin
            addr_in = ADDR_BITS'(item.word_address);
            data_in = item.write_word[WORD_BITS-1:0];
            load    = 1'b1;
            load_m1 = CNT_W'(CMD_LEN - 1);
            tmr_in  = restart;
            if (item.opcode == mwm_pkg::OP_WRITE) begin
               load_ph   = mwm_pkg::PH_EWEN;
               load_bits = SHIFT_W'({mwm_pkg::CMD_EXT, mwm_pkg::EXT_EWEN,
                                     {(ADDR_BITS-2){1'b0}}});
            end else begin
               load_ph   = mwm_pkg::PH_READ;
               load_bits = SHIFT_W'({mwm_pkg::CMD_READ, ADDR_BITS'(item.word_address)});
            end
         end
      end else if (tmr_ff != '0) begin
         tmr_in = tmr_ff - 1'b1;
      end else begin
         tmr_in = restart;
         case (ph_ff)
            mwm_pkg::PH_EWEN, mwm_pkg::PH_WRITE, mwm_pkg::PH_EWDS,
            mwm_pkg::PH_READ: begin
               if (!sk_ff) begin
                  sk_in = 1'b1;
               end else begin
                  cnt_in = cnt_dec;
                  if (cnt_dec != '0) begin
                     cs_in = 1'b1;
                     sk_in = 1'b0;
                     di_in = sh_ff[cnt_m1[IDX_W-1:0]];
                  end else if (ph_ff == mwm_pkg::PH_READ) begin
                     ph_in  = mwm_pkg::PH_CAPTURE;
                     cnt_in = CNT_W'(CAP_LEN);
                     sh_in  = '0;
                     cs_in  = 1'b1;
                     sk_in  = 1'b0;
                     di_in  = 1'b0;
                  end else begin
                     ph_in = ph_ff + 1'b1;
                     cs_in = 1'b0;
                     sk_in = 1'b0;
                     di_in = 1'b0;
                  end
               end
            end
            mwm_pkg::PH_CAPTURE: begin
               if (!sk_ff) begin
                  // sample do just before sk rises
                  sh_in = SHIFT_W'({sh_ff[WORD_BITS-2:0], item.serial_data_out});
                  sk_in = 1'b1;
               end else begin
                  cnt_in = cnt_dec;
                  cs_in  = 1'b0;
                  sk_in  = 1'b0;
                  di_in  = 1'b0;
                  if (cnt_dec == '0) begin
                     rx_in = sh_ff[WORD_BITS-1:0];
                     ph_in = mwm_pkg::PH_READ_GAP;
                  end else begin
                     cs_in = 1'b1;
                  end
               end
            end
            mwm_pkg::PH_EWEN_GAP: begin
               load      = 1'b1;
               load_ph   = mwm_pkg::PH_WRITE;
               load_bits = {mwm_pkg::CMD_WRITE, addr_ff, data_ff};
               load_m1   = CNT_W'(SHIFT_W - 1);
            end
            mwm_pkg::PH_WRITE_GAP: begin
               ph_in  = mwm_pkg::PH_BUSY;
               cnt_in = '0;
               cs_in  = 1'b1;
               sk_in  = 1'b0;
               di_in  = 1'b0;
            end
            mwm_pkg::PH_BUSY: begin
               if (!sk_ff) begin
                  // bit 0 of the counter holds the sampled ready flag
                  cnt_in = CNT_W'(item.serial_data_out);
                  sk_in  = 1'b1;
               end else begin
                  sk_in = 1'b0;
                  di_in = 1'b0;
                  if (cnt_ff[0]) begin
                     ph_in = mwm_pkg::PH_BUSY_GAP;
                     cs_in = 1'b0;
                  end else begin
                     cs_in = 1'b1;
                  end
               end
            end
            mwm_pkg::PH_BUSY_GAP: begin
               load      = 1'b1;
               load_ph   = mwm_pkg::PH_EWDS;
               load_bits = SHIFT_W'({mwm_pkg::CMD_EXT, mwm_pkg::EXT_EWDS,
                                     {(ADDR_BITS-2){1'b0}}});
               load_m1   = CNT_W'(CMD_LEN - 1);
            end
            mwm_pkg::PH_EWDS_GAP, mwm_pkg::PH_READ_GAP: begin
               ph_in  = mwm_pkg::PH_IDLE;
               cnt_in = '0;
               cs_in  = 1'b0;
               sk_in  = 1'b0;
               di_in  = 1'b0;
               rv     = (ph_ff == mwm_pkg::PH_READ_GAP);
               wd     = (ph_ff == mwm_pkg::PH_EWDS_GAP);
            end
            default: begin
               ph_in = mwm_pkg::PH_IDLE;
               cs_in = 1'b0;
               sk_in = 1'b0;
               di_in = 1'b0;
            end
         endcase
      end

      // new command: cs up, sk low, di carries the start bit
      if (load) begin
         ph_in  = load_ph;
         sh_in  = load_bits;
         cnt_in = load_m1 + 1'b1;
         cs_in  = 1'b1;
         sk_in  = 1'b0;
         di_in  = load_bits[load_m1[IDX_W-1:0]];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ph_ff   <= mwm_pkg::PH_IDLE;
         cnt_ff  <= '0;
         sh_ff   <= '0;
         rx_ff   <= '0;
         tmr_ff  <= '0;
         addr_ff <= '0;
         data_ff <= '0;
         cs_ff   <= 1'b0;
         sk_ff   <= 1'b0;
         di_ff   <= 1'b0;
      end else if (step_en) begin
         ph_ff   <= ph_in;
         cnt_ff  <= cnt_in;
         sh_ff   <= sh_in;
         rx_ff   <= rx_in;
         tmr_ff  <= tmr_in;
         addr_ff <= addr_in;
         data_ff <= data_in;
         cs_ff   <= cs_in;
         sk_ff   <= sk_in;
         di_ff   <= di_in;
      end
   end

   always_comb begin
      result.chip_select    = cs_in;
      result.serial_clock   = sk_in;
      result.serial_data_in = di_in;
      result.busy_res       = (ph_in != mwm_pkg::PH_IDLE);
      result.read_valid     = rv;
      result.read_word      = mwm_pkg::DATA_FIELD_W'(rx_in);
      result.write_done     = wd;
   end

endmodule

// File: hdl/microwire_eeprom_master.sv
// Microwire master for a 93C46-style serial EEPROM (x16 organization). Each
// item on the req channel is one timing tick: it may carry a new command
// (taken only while idle) and always carries the sampled DO pin. Each tick
// yields exactly one rsp item with the CS, SK and DI pin levels after that
// tick, a busy flag, a one-tick read_valid with the captured word, and a
// one-tick write_done. A write runs write-enable, the write command with
// 16 data bits, busy polling until DO reads high (no timeout), then
// write-disable; a read sends the read command and captures 17 bits,
// dropping the leading dummy bit. Each pin phase lasts csr ticks_per_phase
// ticks (0 behaves as 1, reset value 1); write it only while idle.
// Rate: one item per clock cycle, sustained under no backpressure. An item
// taken at a clock edge sits in the input register, the phase sequencer
// updates its whole state for that tick in one pass, and the rsp item is
// then held in the result register, from which it is valid. A stalled rsp
// holds the sequencer, and req once both hold items.
module microwire_eeprom_master #(
   parameter int ADDR_BITS = 6,
   parameter int WORD_BITS = 16
) (
   input  logic                       clock,
   input  logic                       reset,

   // tick items in
   input  logic                       req_valid,
   output logic                       req_ready,
   input  mwm_pkg::req_item_type      req_item,

   // pin and status items out
   output logic                       rsp_valid,
   input  logic                       rsp_ready,
   output mwm_pkg::rsp_item_type      rsp_item,

   // ticks_per_phase register
   input  logic                       csr_write_en,
   input  logic [mwm_pkg::TPP_W-1:0]  csr_write_data
);

   logic                       in_vld_ff, in_vld_in;
   mwm_pkg::req_item_type      in_item_ff;
   logic                       out_vld_ff, out_vld_in;
   mwm_pkg::rsp_item_type      out_item_ff;
   logic [mwm_pkg::TPP_W-1:0]  tpp_ff;

   logic                       req_take;
   logic                       step;
   mwm_pkg::rsp_item_type      step_result;

   // the held item steps when the result register is free or being drained
   assign step      = in_vld_ff && (!out_vld_ff || rsp_ready);
   assign req_ready = !in_vld_ff || step;
   assign req_take  = req_valid && req_ready;

   assign in_vld_in  = req_take ? 1'b1 : (step ? 1'b0 : in_vld_ff);
   assign out_vld_in = step ? 1'b1 : (rsp_ready ? 1'b0 : out_vld_ff);

   // config register
   always_ff @(posedge clock) begin
      if (reset) begin
         tpp_ff <= mwm_pkg::TPP_W'(1);
      end else if (csr_write_en) begin
         tpp_ff <= csr_write_data;
      end
   end

   // input register
   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff <= 1'b0;
      end else begin
         in_vld_ff <= in_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         in_item_ff <= req_item;
      end
   end

   // phase sequencer, advanced once per item
   mwm_seq #(
      .ADDR_BITS (ADDR_BITS),
      .WORD_BITS (WORD_BITS)
   ) u_seq (
      .clock           (clock),
      .reset           (reset),
      .step_en         (step),
      .item            (in_item_ff),
      .ticks_per_phase (tpp_ff),
      .result          (step_result)
   );

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         out_vld_ff <= 1'b0;
      end else begin
         out_vld_ff <= out_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (step) begin
         out_item_ff <= step_result;
      end
   end

   assign rsp_valid = out_vld_ff;
   assign rsp_item  = out_item_ff;

endmodule
